// File: rtl/point_in_quadrilateral_macros.svh
// Assertion macros used by the point-in-quadrilateral top level.
`ifndef POINT_IN_QUADRILATERAL_MACROS_SVH
`define POINT_IN_QUADRILATERAL_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PIQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/piq_pkg.sv
// Shared constants and types for the point-in-quadrilateral pipeline.
package piq_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int NUM_EDGES      = 4;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER0_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER0_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER1_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER1_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER2_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER2_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER3_X = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER3_Y = 3'd7;

    // Per-edge flags that travel down the pipeline with each point.
    typedef struct packed {
        logic [NUM_EDGES-1:0] straddle;  // edge spans the horizontal through the point
        logic [NUM_EDGES-1:0] upward;    // start corner lies at or below the point
    } piq_edge_flags_t;

endpackage

// File: rtl/piq_ifs.sv
// Valid/ready channel interfaces for points in and inside flags out.
interface piq_point_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface piq_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

// File: rtl/point_in_quadrilateral.sv
// Top level of the point-in-quadrilateral crossing-number test.
//
//   channel   role     handshake     payload
//   point     sink     valid/ready   point_x, point_y (signed Q16.16)
//   result    source   valid/ready   inside_res
//   cfg_*     write    cfg_we        cfg_index selects a corner coordinate
//
// One point enters per cycle unless a stall on result has backed up to the input;
// each result passes the difference, partial-product, product-sum, and compare
// and parity registers. Each stage holds its beat while the next one is full,
// so a stall on result backs up stage by stage and bubbles close up. Reset
// clears the valid bits and sets every corner to zero.
`include "point_in_quadrilateral_macros.svh"

module point_in_quadrilateral
    import piq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    piq_point_if.sink               point,
    piq_result_if.source            result,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data
);
    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    logic signed [COORD_BITS-1:0] corner_x_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] corner_y_reg [NUM_EDGES];
    logic signed [D-1:0]          ex_reg  [NUM_EDGES];
    logic signed [D-1:0]          ey_reg  [NUM_EDGES];
    logic signed [D-1:0]          ex_next [NUM_EDGES];
    logic signed [D-1:0]          ey_next [NUM_EDGES];

    logic                diff_valid;
    logic signed [D-1:0] diff_dx [NUM_EDGES];
    logic signed [D-1:0] diff_dy [NUM_EDGES];
    piq_edge_flags_t     diff_flags;
    logic                cross_ready;
    logic                cross_valid;
    logic signed [P-1:0] cross_left  [NUM_EDGES];
    logic signed [P-1:0] cross_right [NUM_EDGES];
    piq_edge_flags_t     cross_flags;
    logic                parity_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                corner_x_reg[e] <= '0;
                corner_y_reg[e] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CORNER0_X: corner_x_reg[0] <= cfg_data;
                REG_CORNER0_Y: corner_y_reg[0] <= cfg_data;
                REG_CORNER1_X: corner_x_reg[1] <= cfg_data;
                REG_CORNER1_Y: corner_y_reg[1] <= cfg_data;
                REG_CORNER2_X: corner_x_reg[2] <= cfg_data;
                REG_CORNER2_Y: corner_y_reg[2] <= cfg_data;
                REG_CORNER3_X: corner_x_reg[3] <= cfg_data;
                REG_CORNER3_Y: corner_y_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Edge vectors follow the corners in the next cycle; they are first used
    // by the multiply stage, which a point reaches no earlier than that.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            ex_next[e] = {corner_x_reg[(e + 1) % NUM_EDGES][COORD_BITS-1],
                          corner_x_reg[(e + 1) % NUM_EDGES]}
                       - {corner_x_reg[e][COORD_BITS-1], corner_x_reg[e]};
            ey_next[e] = {corner_y_reg[(e + 1) % NUM_EDGES][COORD_BITS-1],
                          corner_y_reg[(e + 1) % NUM_EDGES]}
                       - {corner_y_reg[e][COORD_BITS-1], corner_y_reg[e]};
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg <= ex_next;
        ey_reg <= ey_next;
    end

    piq_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt       (point),
        .corner_x (corner_x_reg),
        .corner_y (corner_y_reg),
        .take     (cross_ready),
        .valid    (diff_valid),
        .dx       (diff_dx),
        .dy       (diff_dy),
        .flags    (diff_flags)
    );

    piq_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (diff_valid),
        .ready_up (cross_ready),
        .dx       (diff_dx),
        .dy       (diff_dy),
        .flags_in (diff_flags),
        .ex       (ex_reg),
        .ey       (ey_reg),
        .take     (parity_ready),
        .valid    (cross_valid),
        .left     (cross_left),
        .right    (cross_right),
        .flags    (cross_flags)
    );

    piq_parity #(
        .COORD_BITS (COORD_BITS)
    ) u_parity (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (cross_valid),
        .ready_up (parity_ready),
        .left     (cross_left),
        .right    (cross_right),
        .flags_in (cross_flags),
        .res      (result)
    );

    // A closed ring of edges always has an even number of straddling edges.
    `PIQ_ASSERT_IMPLY(a_even_straddle, diff_valid,
        $countones(diff_flags.straddle) == 0 || $countones(diff_flags.straddle) == 2 ||
        $countones(diff_flags.straddle) == 4, "odd straddle count in input stage")

    `PIQ_ASSERT_NEXT(a_input_loads, point.valid && point.ready, diff_valid,
        "accepted point did not reach the input stage")

    `PIQ_ASSERT_NEXT(a_input_holds, diff_valid && !cross_ready,
        diff_valid && $stable(diff_flags) && $stable(diff_dx[0]),
        "input stage changed while stalled")

endmodule

// File: rtl/piq_diff.sv
// Input stage: point minus each corner, and the straddle flags per edge.
module piq_diff
    import piq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,
    piq_point_if.sink                    pt,
    input  logic signed [COORD_BITS-1:0] corner_x [NUM_EDGES],
    input  logic signed [COORD_BITS-1:0] corner_y [NUM_EDGES],
    input  logic                         take,
    output logic                         valid,
    output logic signed [COORD_BITS:0]   dx [NUM_EDGES],
    output logic signed [COORD_BITS:0]   dy [NUM_EDGES],
    output piq_edge_flags_t              flags
);
    localparam int D = COORD_BITS + 1;

    logic                valid_reg;
    logic                valid_next;
    logic signed [D-1:0] dx_reg  [NUM_EDGES];
    logic signed [D-1:0] dy_reg  [NUM_EDGES];
    logic signed [D-1:0] dx_next [NUM_EDGES];
    logic signed [D-1:0] dy_next [NUM_EDGES];
    piq_edge_flags_t     flags_reg;
    piq_edge_flags_t     flags_next;

    assign pt.ready   = !valid_reg || take;
    assign valid_next = pt.ready ? pt.valid : valid_reg;

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            dx_next[e] = {pt.point_x[COORD_BITS-1], pt.point_x}
                       - {corner_x[e][COORD_BITS-1], corner_x[e]};
            dy_next[e] = {pt.point_y[COORD_BITS-1], pt.point_y}
                       - {corner_y[e][COORD_BITS-1], corner_y[e]};
            flags_next.upward[e] = ~dy_next[e][D-1];
        end
        // An edge straddles when its two ends lie on opposite sides of the
        // horizontal, with the lower side inclusive.
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            flags_next.straddle[e] = flags_next.upward[e]
                                   ^ flags_next.upward[(e + 1) % NUM_EDGES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt.ready)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            flags_reg <= flags_next;
        end
    end

    assign valid = valid_reg;
    assign dx    = dx_reg;
    assign dy    = dy_reg;
    assign flags = flags_reg;

endmodule

// File: rtl/piq_cross.sv
// Two-stage cross product per edge: split partial products, then their sums.
module piq_cross
    import piq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid_in,
    output logic                             ready_up,
    input  logic signed [COORD_BITS:0]       dx [NUM_EDGES],
    input  logic signed [COORD_BITS:0]       dy [NUM_EDGES],
    input  piq_edge_flags_t                  flags_in,
    input  logic signed [COORD_BITS:0]       ex [NUM_EDGES],
    input  logic signed [COORD_BITS:0]       ey [NUM_EDGES],
    input  logic                             take,
    output logic                             valid,
    output logic signed [2*COORD_BITS+1:0]   left [NUM_EDGES],
    output logic signed [2*COORD_BITS+1:0]   right [NUM_EDGES],
    output piq_edge_flags_t                  flags
);
    localparam int D      = COORD_BITS + 1;
    localparam int K      = D / 2;
    localparam int P      = 2 * D;
    localparam int LOW_W  = D + K + 1;
    localparam int HIGH_W = 2 * D - K;

    logic                     v2_reg;
    logic                     v2_next;
    logic                     v3_reg;
    logic                     v3_next;
    logic                     take2;
    logic                     take3;
    logic signed [LOW_W-1:0]  l_lo_reg  [NUM_EDGES];
    logic signed [HIGH_W-1:0] l_hi_reg  [NUM_EDGES];
    logic signed [LOW_W-1:0]  r_lo_reg  [NUM_EDGES];
    logic signed [HIGH_W-1:0] r_hi_reg  [NUM_EDGES];
    logic signed [LOW_W-1:0]  l_lo_next [NUM_EDGES];
    logic signed [HIGH_W-1:0] l_hi_next [NUM_EDGES];
    logic signed [LOW_W-1:0]  r_lo_next [NUM_EDGES];
    logic signed [HIGH_W-1:0] r_hi_next [NUM_EDGES];
    piq_edge_flags_t          flags2_reg;
    piq_edge_flags_t          flags3_reg;
    logic signed [P-1:0]      left_reg   [NUM_EDGES];
    logic signed [P-1:0]      right_reg  [NUM_EDGES];
    logic signed [P-1:0]      left_next  [NUM_EDGES];
    logic signed [P-1:0]      right_next [NUM_EDGES];

    assign take3    = !v3_reg || take;
    assign take2    = !v2_reg || take3;
    assign ready_up = take2;
    assign v2_next  = take2 ? valid_in : v2_reg;
    assign v3_next  = take3 ? v2_reg : v3_reg;

    // The edge vector operand is split into an unsigned low part and a signed
    // high part so that no single multiplier spans the full operand width.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            l_lo_next[e] = LOW_W'(dx[e]) * LOW_W'($signed({1'b0, ey[e][K-1:0]}));
            l_hi_next[e] = HIGH_W'(dx[e]) * HIGH_W'($signed(ey[e][D-1:K]));
            r_lo_next[e] = LOW_W'(dy[e]) * LOW_W'($signed({1'b0, ex[e][K-1:0]}));
            r_hi_next[e] = HIGH_W'(dy[e]) * HIGH_W'($signed(ex[e][D-1:K]));
        end
    end

    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            left_next[e]  = $signed({l_hi_reg[e][P-K-1:0], {K{1'b0}}})
                          + $signed({{(P-LOW_W){l_lo_reg[e][LOW_W-1]}}, l_lo_reg[e]});
            right_next[e] = $signed({r_hi_reg[e][P-K-1:0], {K{1'b0}}})
                          + $signed({{(P-LOW_W){r_lo_reg[e][LOW_W-1]}}, r_lo_reg[e]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            l_lo_reg   <= l_lo_next;
            l_hi_reg   <= l_hi_next;
            r_lo_reg   <= r_lo_next;
            r_hi_reg   <= r_hi_next;
            flags2_reg <= flags_in;
        end
        if (take3)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            flags3_reg <= flags2_reg;
        end
    end

    assign valid = v3_reg;
    assign left  = left_reg;
    assign right = right_reg;
    assign flags = flags3_reg;

endmodule

// File: rtl/piq_parity.sv
// Output stage: per-edge left-of decision, crossing parity and result register.
module piq_parity
    import piq_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    output logic                           ready_up,
    input  logic signed [2*COORD_BITS+1:0] left [NUM_EDGES],
    input  logic signed [2*COORD_BITS+1:0] right [NUM_EDGES],
    input  piq_edge_flags_t                flags_in,
    piq_result_if.source                   res
);
    logic                 valid_reg;
    logic                 valid_next;
    logic                 inside_reg;
    logic                 inside_next;
    logic                 take;
    logic [NUM_EDGES-1:0] hit;

    assign take       = !valid_reg || res.ready;
    assign ready_up   = take;
    assign valid_next = take ? valid_in : valid_reg;

    // With the edge pointing up the point is left when left < right; an edge
    // pointing down flips both sides of the comparison.
    always_comb
    begin
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            hit[e] = flags_in.straddle[e]
                   & (flags_in.upward[e] ? (left[e] < right[e]) : (left[e] > right[e]));
        end
        inside_next = ^hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            inside_reg <= inside_next;
        end
    end

    assign res.valid      = valid_reg;
    assign res.inside_res = inside_reg;

endmodule
